### design/utf8_safe_text_chunker_crlf_assert.svh
// assertion macros shared by the chunker rtl
`ifndef UTF8_SAFE_TEXT_CHUNKER_CRLF_ASSERT_SVH
`define UTF8_SAFE_TEXT_CHUNKER_CRLF_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define USTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define USTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ustc_pkg.sv
// ---------------------------------------------------------------------------
// ustc_pkg
// shared types, constants and helpers of the utf-8 safe text chunker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ustc_pkg;

  localparam int STORE_DEPTH = 5;   // cr + lf on top of a held tail of three
  localparam int LEN_W       = 3;   // holds 0 .. STORE_DEPTH
  localparam int FIFO_DEPTH  = 2;   // frames between front and back

  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_QMARK = 8'h3F;

  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;
  localparam logic [1:0] CONT_TAG   = 2'b10;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_CLOSE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [STORE_DEPTH-1:0][7:0] bytes;
    logic [LEN_W-1:0]            len;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_sts_t;

  typedef struct packed {
    logic [LEN_W-1:0] pend_cnt;
  } front_sts_t;

  // sequence length announced by a byte; ascii and bad leads stand alone
  function automatic logic [LEN_W-1:0] seq_need(input logic [7:0] b);
    logic [LEN_W-1:0] need;
    need = LEN_W'(1);
    if ((b & MASK_LEAD2) == CODE_LEAD2) begin
      need = LEN_W'(2);
    end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
      need = LEN_W'(3);
    end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
      need = LEN_W'(4);
    end
    return need;
  endfunction

endpackage

`default_nettype wire

### design/ustc_in_if.sv
// ---------------------------------------------------------------------------
// ustc_in_if
// request channel into the chunker: operation, byte and call-start flag
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ustc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;
  logic       first_in_call;

  modport source (output valid, operation, data_byte, first_in_call, input ready);
  modport sink   (input valid, operation, data_byte, first_in_call, output ready);
endinterface

`default_nettype wire

### design/ustc_out_if.sv
// ---------------------------------------------------------------------------
// ustc_out_if
// frame byte channel out of the chunker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ustc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_in_frame;

  modport source (output valid, out_byte, last_in_frame, input ready);
  modport sink   (input valid, out_byte, last_in_frame, output ready);
endinterface

`default_nettype wire

### design/ustc_fifo.sv
// ---------------------------------------------------------------------------
// ustc_fifo
// short frame queue between the classifying front and the serialising back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ustc_fifo #(
  parameter int Depth = ustc_pkg::FIFO_DEPTH
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  ustc_pkg::frame_t     wdata_i,
  input  wire                  pop_i,
  output ustc_pkg::frame_t     rdata_o,
  output ustc_pkg::fifo_sts_t  sts_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ustc_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o     = mem_q[rd_ptr_q];
  assign sts_o.full  = (cnt_q == CntW'(Depth));
  assign sts_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

### design/ustc_front.sv
// ---------------------------------------------------------------------------
// ustc_front
// takes requests, expands lf to cr lf, finds the complete utf-8 prefix
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ustc_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  ustc_in_if.sink               in_i,
  input  ustc_pkg::fifo_sts_t   fifo_sts_i,
  output logic                  push_o,
  output ustc_pkg::frame_t      frame_o,
  output ustc_pkg::front_sts_t  sts_o
);

  localparam int SD = ustc_pkg::STORE_DEPTH;
  localparam int LW = ustc_pkg::LEN_W;

  logic [7:0]    pend_q [SD];
  logic [LW-1:0] cnt_q, cnt_d;
  logic [7:0]    prev_q;

  logic          accept;
  logic          is_close;
  logic          ins_cr;
  logic [LW-1:0] len;
  logic [7:0]    ext [SD];
  logic [7:0]    ext_pad [2*SD];
  logic [7:0]    cont_pad;
  logic [LW-1:0] need_v [SD];
  logic [SD-1:0] ok_v;
  logic [LW-1:0] span_pad [8];
  logic [LW-1:0] n;

  assign in_i.ready = !fifo_sts_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign is_close   = (in_i.operation == ustc_pkg::OP_CLOSE);

  // lf gets a cr unless the previous byte of this call was a cr
  assign ins_cr = (in_i.data_byte == ustc_pkg::BYTE_LF) &&
                  (in_i.first_in_call || (prev_q != ustc_pkg::BYTE_CR));
  assign len    = cnt_q + LW'(1) + LW'(ins_cr);

  // held tail, then optional cr, then the new byte
  always_comb begin
    for (int i = 0; i < SD; i++) begin
      if (i < int'(cnt_q)) begin
        ext[i] = pend_q[i];
      end else if (i == int'(cnt_q)) begin
        ext[i] = ins_cr ? ustc_pkg::BYTE_CR : in_i.data_byte;
      end else if ((i == int'(cnt_q) + 1) && ins_cr) begin
        ext[i] = in_i.data_byte;
      end else begin
        ext[i] = '0;
      end
    end
    for (int i = 0; i < 2 * SD; i++) begin
      ext_pad[i] = (i < SD) ? ext[i % SD] : '0;
    end
    for (int i = 0; i < 8; i++) begin
      cont_pad[i] = (i < SD) ? (ext[i % SD][7:6] == ustc_pkg::CONT_TAG) : 1'b0;
    end
  end

  // character span at each position, zero where the sequence is incomplete
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      span_pad[p] = '0;
    end
    for (int p = 0; p < SD; p++) begin
      need_v[p] = ustc_pkg::seq_need(ext[p]);
      ok_v[p]   = 1'b1;
      for (int k = 1; k < 4; k++) begin
        if ((k < int'(need_v[p])) && !cont_pad[(p + k) % 8]) begin
          ok_v[p] = 1'b0;
        end
      end
      if (p >= int'(len)) begin
        span_pad[p] = '0;
      end else if (p + int'(need_v[p]) > int'(len)) begin
        span_pad[p] = '0;
      end else if (!ok_v[p]) begin
        span_pad[p] = LW'(1);
      end else begin
        span_pad[p] = need_v[p];
      end
    end
  end

  // walk the prefix; a zero span leaves the position where it is
  always_comb begin
    n = '0;
    for (int s = 0; s < SD; s++) begin
      if (n < len) begin
        n = n + span_pad[n];
      end
    end
  end

  always_comb begin
    frame_o = '0;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    if (is_close) begin
      frame_o.bytes[0] = ustc_pkg::BYTE_QMARK;
      frame_o.len      = LW'(1);
      push_o           = accept && (cnt_q != '0);
      cnt_d            = '0;
    end else begin
      for (int i = 0; i < SD; i++) begin
        frame_o.bytes[i] = ext[i];
      end
      frame_o.len = n;
      push_o      = accept && (n != '0);
      cnt_d       = len - n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      if (!is_close) begin
        prev_q <= in_i.data_byte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_close) begin
      for (int i = 0; i < SD; i++) begin
        pend_q[i] <= ext_pad[i + int'(n)];
      end
    end
  end

  assign sts_o.pend_cnt = cnt_q;

endmodule

`default_nettype wire

### design/ustc_back.sv
// ---------------------------------------------------------------------------
// ustc_back
// sends queued frames out one byte per cycle, while the receiver takes them, through an output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ustc_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  ustc_pkg::frame_t  head_i,
  input  wire               head_valid_i,
  output logic              pop_o,
  ustc_out_if.source        out_o
);

  localparam int LW = ustc_pkg::LEN_W;

  logic [LW-1:0] idx_q;
  logic          valid_q;
  logic [7:0]    byte_q;
  logic          last_q;

  logic          load;
  logic          is_last;

  assign load    = head_valid_i && (!valid_q || out_o.ready);
  assign is_last = ((idx_q + LW'(1)) == head_i.len);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= is_last ? '0 : idx_q + LW'(1);
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      last_q <= is_last;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.last_in_frame = last_q;

endmodule

`default_nettype wire

### design/utf8_safe_text_chunker_crlf.sv
// The chunker takes one request per cycle (append a text byte, or close) whenever its frame
// queue has room, and hands out frame bytes one per cycle while the receiver is ready on the
// output channel, with last_in_frame on the final byte of each frame. Appending adds a cr
// before an lf that does not follow a cr of the same write call, and releases the longest run
// of complete utf-8 characters held so far as one frame; up to three bytes of an unfinished
// character stay behind. Close turns such a tail into a single '?' frame. A request is
// classified in the cycle it is accepted; its frame then passes through the frame queue into
// the output register, and a sustained stream of plain text runs at one byte per cycle while
// the receiver is ready. A frame of k bytes holds the output side while its k bytes go out;
// the frame queue (FifoDepth frames) absorbs that while the input side keeps going, and input
// ready drops only when the queue is full. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_safe_text_chunker_crlf_assert.svh"

// ---------------------------------------------------------------------------
// utf8_safe_text_chunker_crlf
// lf to cr lf expansion with utf-8 safe framing of an outgoing byte stream
// ---------------------------------------------------------------------------
module utf8_safe_text_chunker_crlf #(
  parameter int FifoDepth = ustc_pkg::FIFO_DEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ustc_in_if.sink    in_i,
  ustc_out_if.source out_o
);

  // front to queue
  logic                 fifo_push;
  ustc_pkg::frame_t     fifo_wdata;
  ustc_pkg::front_sts_t front_sts;

  // queue to back
  logic                 fifo_pop;
  ustc_pkg::frame_t     fifo_head;
  ustc_pkg::fifo_sts_t  fifo_sts;

  // front: request intake, cr insertion, prefix search, held tail
  ustc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .fifo_sts_i (fifo_sts),
    .push_o     (fifo_push),
    .frame_o    (fifo_wdata),
    .sts_o      (front_sts)
  );

  // frame queue decouples intake from the byte serialiser
  ustc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .pop_i   (fifo_pop),
    .rdata_o (fifo_head),
    .sts_o   (fifo_sts)
  );

  // back: one frame byte per cycle into the output register while the receiver is ready
  ustc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (fifo_head),
    .head_valid_i (!fifo_sts.empty),
    .pop_o        (fifo_pop),
    .out_o        (out_o)
  );

  // a frame is never written into a full queue
  `USTC_ASSERT_IMP(a_push_room, clk_i, rst_ni, fifo_push, !fifo_sts.full, "push into full queue")

  // close with a held tail leaves a frame queued
  `USTC_ASSERT_NXT(a_close_frame, clk_i, rst_ni, in_i.valid && in_i.ready && (in_i.operation == ustc_pkg::OP_CLOSE) && (front_sts.pend_cnt != '0), !fifo_sts.empty, "close lost its frame")

  // output only comes alive from a queued frame
  `USTC_ASSERT_IMP(a_out_source, clk_i, rst_ni, $rose(out_o.valid), $past(!fifo_sts.empty), "output without frame")

endmodule

`default_nettype wire

### dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the utf-8 safe text chunker: a predictor of the
// cr insertion and the utf-8 framing follows every accepted request, and
// each frame byte that leaves the block is compared with its expectation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IDLE_LIMIT   = 1000;  // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 60;    // long receiver hold-off

  // one expected frame byte
  typedef struct {
    logic [7:0] out_byte;
    logic       last_in_frame;
  } frame_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ustc_in_if  in_if ();
  ustc_out_if out_if ();

  utf8_safe_text_chunker_crlf DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor state: held bytes of an unfinished character, and the last
  // appended text byte for the cr-before-lf rule
  logic [7:0]  held_bytes [ustc_pkg::STORE_DEPTH];
  int unsigned held_count     = 0;
  logic [7:0]  last_text_byte = 8'h00;

  frame_byte_t expected_frame_bytes [$];

  int unsigned send_idle_pct        = 0;
  int unsigned recv_stall_pct       = 0;
  int unsigned receiver_hold_cycles = 0;
  int unsigned mismatch_count       = 0;
  int unsigned idle_cycles          = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // bytes the character at pos occupies, 0 while it is still incomplete
  function automatic int unsigned char_span(input int unsigned pos);
    logic [7:0]  lead;
    int unsigned need;
    int unsigned k;
    if (pos >= held_count) return 0;
    lead = held_bytes[pos];
    if (lead[7] == 1'b0) return 1;
    if ((lead & ustc_pkg::MASK_LEAD2) == ustc_pkg::CODE_LEAD2) begin
      need = 2;
    end else if ((lead & ustc_pkg::MASK_LEAD3) == ustc_pkg::CODE_LEAD3) begin
      need = 3;
    end else if ((lead & ustc_pkg::MASK_LEAD4) == ustc_pkg::CODE_LEAD4) begin
      need = 4;
    end else begin
      return 1;                    // stray continuation or 0xf8 and above
    end
    if (pos + need > held_count) return 0;
    for (k = 1; k < need; k++) begin
      // a bad continuation lets the lead go out on its own
      if (held_bytes[pos + k][7:6] != ustc_pkg::CONT_TAG) return 1;
    end
    return need;
  endfunction

  function automatic void hold_byte(input logic [7:0] b);
    if (held_count < ustc_pkg::STORE_DEPTH) begin
      held_bytes[held_count] = b;
      held_count++;
    end
  endfunction

  // works out the frame bytes that one accepted request releases
  function automatic void predict_request(input ustc_pkg::op_e op, input logic [7:0] b,
                                          input logic first);
    int unsigned done;
    int unsigned span;
    int unsigned k;
    if (op == ustc_pkg::OP_CLOSE) begin
      // an unfinished tail collapses into a single '?' frame
      if (held_count != 0) begin
        expected_frame_bytes.push_back('{ustc_pkg::BYTE_QMARK, 1'b1});
        held_count = 0;
      end
      return;
    end
    if (b == ustc_pkg::BYTE_LF && (first || last_text_byte != ustc_pkg::BYTE_CR)) begin
      hold_byte(ustc_pkg::BYTE_CR);
    end
    hold_byte(b);
    last_text_byte = b;
    done = 0;
    while (done < held_count) begin
      span = char_span(done);
      if (span == 0) break;
      done += span;
    end
    for (k = 0; k < done; k++) begin
      expected_frame_bytes.push_back('{held_bytes[k], logic'(k + 1 == done)});
    end
    for (k = 0; k + done < held_count; k++) begin
      held_bytes[k] = held_bytes[k + done];
    end
    held_count -= done;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one request after a random gap and waits for it to be taken
  task automatic send_request(input ustc_pkg::op_e op, input logic [7:0] b,
                              input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= op;
    in_if.data_byte     <= b;
    in_if.first_in_call <= first;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_request(op, b, first);
  endtask

  task automatic append_byte(input logic [7:0] b, input logic first);
    send_request(ustc_pkg::OP_APPEND, b, first);
  endtask

  task automatic close_call();
    send_request(ustc_pkg::OP_CLOSE, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // sender goes quiet until every expected frame byte has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_frame_bytes.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // response side: random stalls, plus a long hold-off counted down here
  // ---------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (receiver_hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        receiver_hold_cycles--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // frame byte checker against the oldest expectation
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_frame_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte %h last %b", $time,
                 out_if.out_byte, out_if.last_in_frame);
        mismatch_count++;
      end else begin
        want = expected_frame_bytes.pop_front();
        if (out_if.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h, got %h", $time,
                   want.out_byte, out_if.out_byte);
          mismatch_count++;
        end
        if (out_if.last_in_frame !== want.last_in_frame) begin
          $display("%0t: last_in_frame expected %b, got %b", $time,
                   want.last_in_frame, out_if.last_in_frame);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d frame bytes still expected", $time,
               expected_frame_bytes.size());
      $display("utf8_safe_text_chunker_crlf: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // random byte helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_lead(input int unsigned seq_len);
    logic [7:0] b;
    b = 8'($urandom_range(255));
    case (seq_len)
      2:       b[7:5] = 3'b110;
      3:       b[7:4] = 4'b1110;
      default: b[7:3] = 5'b11110;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rand_cont();
    return {ustc_pkg::CONT_TAG, 6'($urandom_range(63))};
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // close with nothing held, then plain ascii
  task automatic test_plain_text();
    close_call();
    append_byte(8'h41, 1'b1);
    wait_drained();
  endtask

  // lf alone, cr lf within one call, cr lf across two calls
  task automatic test_crlf_expansion();
    append_byte(ustc_pkg::BYTE_LF, 1'b1);
    append_byte(ustc_pkg::BYTE_CR, 1'b0);
    append_byte(ustc_pkg::BYTE_LF, 1'b0);
    append_byte(ustc_pkg::BYTE_CR, 1'b0);
    append_byte(ustc_pkg::BYTE_LF, 1'b1);
    wait_drained();
  endtask

  // two and four byte characters released only once complete
  task automatic test_multibyte_sequences();
    append_byte(8'hC3, 1'b1);
    append_byte(8'hA9, 1'b0);
    append_byte(8'hF0, 1'b0);
    append_byte(8'h9F, 1'b0);
    append_byte(8'h98, 1'b0);
    append_byte(8'h80, 1'b0);
    wait_drained();
  endtask

  // bad continuation, stray continuation, invalid lead
  task automatic test_broken_sequences();
    append_byte(8'hC3, 1'b1);
    append_byte(8'h41, 1'b0);
    append_byte(8'h80, 1'b0);
    append_byte(8'hFF, 1'b0);
    wait_drained();
  endtask

  // unfinished three byte character turned into '?' on close
  task automatic test_close_flush();
    append_byte(8'hE2, 1'b1);
    append_byte(8'h82, 1'b0);
    close_call();
    wait_drained();
  endtask

  // full held tail with cr lf on top: five bytes out in one frame
  task automatic test_tail_then_lf();
    append_byte(8'hF0, 1'b1);
    append_byte(8'h9F, 1'b0);
    append_byte(8'h98, 1'b0);
    append_byte(ustc_pkg::BYTE_LF, 1'b0);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so input ready drops
  task automatic test_backpressure_fill();
    int unsigned k;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    receiver_hold_cycles = HOLD_CYCLES;
    for (k = 0; k < 20; k++) begin
      append_byte(8'($urandom_range(8'h7F)), 1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  // mostly well formed text with random content, some noise and broken runs
  task automatic test_random_text(input int unsigned n_items, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    int unsigned sent;
    int unsigned kind;
    int unsigned seq_len;
    int unsigned cut;
    int unsigned k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        append_byte(8'($urandom_range(8'h7F)), ($urandom_range(3) == 0));
        sent++;
      end else if (kind < 60) begin
        // complete character of two to four bytes
        seq_len = $urandom_range(2, 4);
        append_byte(rand_lead(seq_len), ($urandom_range(3) == 0));
        for (k = 1; k < seq_len; k++) append_byte(rand_cont(), ($urandom_range(7) == 0));
        sent += seq_len;
      end else if (kind < 75) begin
        // character cut short and followed by any byte
        seq_len = $urandom_range(2, 4);
        cut     = $urandom_range(seq_len - 2);
        append_byte(rand_lead(seq_len), ($urandom_range(3) == 0));
        for (k = 0; k < cut; k++) append_byte(rand_cont(), 1'b0);
        append_byte(8'($urandom_range(255)), ($urandom_range(3) == 0));
        sent += cut + 2;
      end else if (kind < 85) begin
        append_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent++;
      end else if (kind < 93) begin
        // line ends, with or without the cr already there
        if ($urandom_range(1)) begin
          append_byte(ustc_pkg::BYTE_CR, ($urandom_range(3) == 0));
          sent++;
        end
        append_byte(ustc_pkg::BYTE_LF, ($urandom_range(3) == 0));
        sent++;
      end else begin
        close_call();
        sent++;
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_if.valid         <= 1'b0;
    in_if.operation     <= ustc_pkg::OP_APPEND;
    in_if.data_byte     <= 8'h00;
    in_if.first_in_call <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_text();
    test_crlf_expansion();
    test_multibyte_sequences();
    test_broken_sequences();
    test_close_flush();
    test_tail_then_lf();
    test_backpressure_fill();
    test_random_text(42, 0, 0);
    test_random_text(42, 76, 0);
    test_random_text(42, 0, 76);
    test_random_text(42, 38, 38);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("utf8_safe_text_chunker_crlf: match");
    end else begin
      $display("utf8_safe_text_chunker_crlf: mismatch");
    end
    $finish;
  end

endmodule
